>>> rtl/edge_timing_autobaud_detector_top_macros.svh
// Assertion helpers for the autobaud detector, clocked on i_clk and
// held off while i_rst_n is low.
`ifndef EDGE_TIMING_AUTOBAUD_DETECTOR_TOP_MACROS_SVH
`define EDGE_TIMING_AUTOBAUD_DETECTOR_TOP_MACROS_SVH

// Condition that must hold at every edge
`define ETAB_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the same cycle as the antecedent
`define ETAB_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/etab_pkg.sv
`timescale 1ns / 1ps

package etab_pkg;

    // Timestamp width; intervals wrap at this many bits
    localparam int TIME_BITS  = 32;

    localparam int FUNC_W     = 2;
    localparam int TICK_W     = 27;
    localparam int NOISE_W    = 10;
    localparam int CNT_W      = 8;
    localparam int BAUD_W     = 17;
    // Shortest interval never exceeds one million, so 20 bits hold it
    localparam int SHORT_W    = 20;
    localparam int CMP_W      = (TIME_BITS > SHORT_W) ? TIME_BITS : SHORT_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TICK_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_CNT_W   = $clog2(TICK_W);
    localparam int RATE_COUNT  = 8;
    localparam int RATE_IDX_W  = $clog2(RATE_COUNT);

    localparam logic [SHORT_W-1:0] INITIAL_SHORTEST = SHORT_W'(1000000);
    localparam logic [SHORT_W-1:0] MATCH_BOUND      = SHORT_W'(1000000);

    // Function codes of the input word
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVAL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EDGES = 3'd3;

    localparam logic [TICK_W-1:0]  RST_TICKS     = TICK_W'(1000000);
    localparam logic [NOISE_W-1:0] RST_NOISE     = NOISE_W'(2);
    localparam logic [CNT_W-1:0]   RST_EDGE_LIM  = CNT_W'(50);
    localparam logic [CNT_W-1:0]   RST_MIN_EDGES = CNT_W'(5);

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [TIME_BITS-1:0] edge_time;
    } t_in_word;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_rate;
        logic [TICK_W-1:0] measured_rate;
        logic              status;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_START,
        OP_EDGE,
        OP_EVAL
    } t_op;

    // Command word queued between front and back
    typedef struct packed {
        t_op                  op;
        logic [TIME_BITS-1:0] interval;
    } t_cmd;

    typedef struct packed {
        logic [TICK_W-1:0]  ticks_per_second;
        logic [NOISE_W-1:0] noise_floor;
        logic [CNT_W-1:0]   edge_limit;
        logic [CNT_W-1:0]   min_edges;
    } t_cfg;

    typedef struct packed {
        logic               busy;
        logic               res_pending;
        logic [CNT_W-1:0]   kept_count;
        logic [SHORT_W-1:0] shortest;
    } t_be_stat;

    // Standard rates in ascending order
    function automatic logic [BAUD_W-1:0] std_rate(input logic [RATE_IDX_W-1:0] k);
        logic [BAUD_W-1:0] r;
        case (k)
            3'd0:    r = BAUD_W'(1200);
            3'd1:    r = BAUD_W'(2400);
            3'd2:    r = BAUD_W'(4800);
            3'd3:    r = BAUD_W'(9600);
            3'd4:    r = BAUD_W'(19200);
            3'd5:    r = BAUD_W'(38400);
            3'd6:    r = BAUD_W'(57600);
            default: r = BAUD_W'(115200);
        endcase
        return r;
    endfunction

endpackage

>>> rtl/etab_fe.sv
`timescale 1ns / 1ps

module etab_fe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  etab_pkg::t_in_word i_in_data,
    input  logic             i_full,
    output logic             o_push,
    output etab_pkg::t_cmd   o_cmd
);

    logic [etab_pkg::TIME_BITS-1:0] r_last_edge;
    logic                           accept;
    logic                           is_time;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_time    = (i_in_data.func == etab_pkg::FUNC_START) ||
                        (i_in_data.func == etab_pkg::FUNC_EDGE);

    // Classify the word; unused code is dropped here
    always_comb begin
        o_cmd.interval = i_in_data.edge_time - r_last_edge;
        o_push         = accept;
        case (i_in_data.func)
            etab_pkg::FUNC_START: o_cmd.op = etab_pkg::OP_START;
            etab_pkg::FUNC_EDGE:  o_cmd.op = etab_pkg::OP_EDGE;
            etab_pkg::FUNC_EVAL:  o_cmd.op = etab_pkg::OP_EVAL;
            default: begin
                o_cmd.op = etab_pkg::OP_EVAL;
                o_push   = 1'b0;
            end
        endcase
    end

    // Last edge or start time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
        end else if (accept && is_time) begin
            r_last_edge <= i_in_data.edge_time;
        end
    end

endmodule

>>> rtl/etab_fifo.sv
`timescale 1ns / 1ps

module etab_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  etab_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output etab_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    etab_pkg::t_cmd                r_mem [etab_pkg::QUEUE_DEPTH];
    logic [etab_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [etab_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [etab_pkg::QCNT_W-1:0]   r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == etab_pkg::QCNT_W'(etab_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    function automatic logic [etab_pkg::QPTR_W-1:0] ptr_next(
        input logic [etab_pkg::QPTR_W-1:0] p);
        if (p == etab_pkg::QPTR_W'(etab_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/etab_be.sv
`timescale 1ns / 1ps

module etab_be (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etab_pkg::t_cfg      i_cfg,
    input  etab_pkg::t_cmd      i_cmd,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output etab_pkg::t_out_word o_out_data,
    output etab_pkg::t_be_stat  o_stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PICK,
        ST_HOLD
    } t_state;

    t_state                             r_state;
    logic [etab_pkg::CNT_W-1:0]         r_kept;
    logic [etab_pkg::SHORT_W-1:0]       r_shortest;
    logic [etab_pkg::SHORT_W-1:0]       r_rem;
    logic [etab_pkg::TICK_W-1:0]        r_quo;
    logic [etab_pkg::DIV_CNT_W-1:0]     r_step;
    logic [etab_pkg::RATE_IDX_W-1:0]    r_k;
    logic [etab_pkg::BAUD_W-1:0]        r_best;
    logic [etab_pkg::SHORT_W-1:0]       r_best_diff;
    etab_pkg::t_out_word                r_res;
    logic                               r_out_valid;
    etab_pkg::t_out_word                r_out_data;

    logic [etab_pkg::SHORT_W:0]         div_trial;
    logic [etab_pkg::SHORT_W:0]         div_sub;
    logic                               div_ge;
    logic [etab_pkg::TICK_W-1:0]        cand_rate;
    logic [etab_pkg::TICK_W-1:0]        cand_diff;
    logic                               cand_better;
    logic [etab_pkg::BAUD_W-1:0]        pick_best;
    logic                               keep_edge;

    assign o_pop       = (r_state == ST_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.busy        = (r_state != ST_IDLE);
    assign o_stat.res_pending = (r_state == ST_HOLD);
    assign o_stat.kept_count  = r_kept;
    assign o_stat.shortest    = r_shortest;

    // Edge filter: room left and above the noise floor
    assign keep_edge = (r_kept < i_cfg.edge_limit) &&
                       (etab_pkg::CMP_W'(i_cmd.interval) >
                        etab_pkg::CMP_W'(i_cfg.noise_floor));

    // One restoring divider step a cycle
    assign div_trial = {r_rem, r_quo[etab_pkg::TICK_W-1]};
    assign div_sub   = div_trial - {1'b0, r_shortest};
    assign div_ge    = (div_trial >= {1'b0, r_shortest});

    // One standard rate tried a cycle
    assign cand_rate   = etab_pkg::TICK_W'(etab_pkg::std_rate(r_k));
    assign cand_diff   = (r_quo >= cand_rate) ? (r_quo - cand_rate) : (cand_rate - r_quo);
    assign cand_better = (cand_diff < etab_pkg::TICK_W'(r_best_diff));
    assign pick_best   = cand_better ? etab_pkg::std_rate(r_k) : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kept      <= '0;
            r_shortest  <= etab_pkg::INITIAL_SHORTEST;
            r_out_valid <= 1'b0;
        end else begin
            // Word taken with nothing new to load behind it
            if (r_out_valid && i_out_ready && (r_state != ST_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.op)
                            etab_pkg::OP_START: begin
                                r_kept     <= '0;
                                r_shortest <= etab_pkg::INITIAL_SHORTEST;
                            end
                            etab_pkg::OP_EDGE: begin
                                if (keep_edge) begin
                                    r_kept <= r_kept + 1'b1;
                                    if (etab_pkg::CMP_W'(i_cmd.interval) <
                                        etab_pkg::CMP_W'(r_shortest)) begin
                                        r_shortest <= etab_pkg::SHORT_W'(i_cmd.interval);
                                    end
                                end
                            end
                            etab_pkg::OP_EVAL: begin
                                if (r_kept < i_cfg.min_edges) begin
                                    r_res.baud_rate     <= '0;
                                    r_res.measured_rate <= '0;
                                    r_res.status        <= 1'b1;
                                    r_state             <= ST_HOLD;
                                end else begin
                                    r_rem   <= '0;
                                    r_quo   <= i_cfg.ticks_per_second;
                                    r_step  <= '0;
                                    r_state <= ST_DIV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_rem  <= div_ge ? div_sub[etab_pkg::SHORT_W-1:0]
                                     : div_trial[etab_pkg::SHORT_W-1:0];
                    r_quo  <= {r_quo[etab_pkg::TICK_W-2:0], div_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == etab_pkg::DIV_CNT_W'(etab_pkg::TICK_W - 1)) begin
                        r_k         <= '0;
                        r_best      <= '0;
                        r_best_diff <= etab_pkg::MATCH_BOUND;
                        r_state     <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (cand_better) begin
                        r_best      <= etab_pkg::std_rate(r_k);
                        r_best_diff <= etab_pkg::SHORT_W'(cand_diff);
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == etab_pkg::RATE_IDX_W'(etab_pkg::RATE_COUNT - 1)) begin
                        r_res.baud_rate     <= pick_best;
                        r_res.measured_rate <= r_quo;
                        r_res.status        <= 1'b0;
                        r_state             <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    // Wait for the output register to free up
                    if (!r_out_valid || i_out_ready) begin
                        r_out_data  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/edge_timing_autobaud_detector_top.sv
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// in       i_in_valid / o_in_ready   i_in_data  (func, edge_time)
// out      o_out_valid / i_out_ready o_out_data (baud_rate, measured_rate, status)
// cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A word is written into the queue on the edge that accepts it; start and edge
// words retire in the back end without leaving the idle state.
// Evaluate with enough edges goes from queue to output register by a pop,
// the one-bit-a-cycle divider, a scan of the standard rates and a load;
// a too-few result takes only the pop and the load.
// Reset is synchronous; there is no clearing pass.
// A two-word queue parts front from back and an output register parts back
// from the consumer; input stalls only once the queue is full.

`include "edge_timing_autobaud_detector_top_macros.svh"

module edge_timing_autobaud_detector_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  etab_pkg::t_in_word                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output etab_pkg::t_out_word               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [etab_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [etab_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    etab_pkg::t_cfg     r_cfg;
    etab_pkg::t_cmd     fe_cmd;
    etab_pkg::t_cmd     q_cmd;
    etab_pkg::t_be_stat stat;
    logic               fe_push;
    logic               q_full;
    logic               q_empty;
    logic               be_pop;
    logic               shortest_ok;
    logic               too_few_out;
    logic               rates_zero;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second <= etab_pkg::RST_TICKS;
            r_cfg.noise_floor      <= etab_pkg::RST_NOISE;
            r_cfg.edge_limit       <= etab_pkg::RST_EDGE_LIM;
            r_cfg.min_edges        <= etab_pkg::RST_MIN_EDGES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                etab_pkg::CFG_TICKS:
                    r_cfg.ticks_per_second <= i_cfg_data;
                etab_pkg::CFG_NOISE:
                    r_cfg.noise_floor <= i_cfg_data[etab_pkg::NOISE_W-1:0];
                etab_pkg::CFG_EDGE_LIM:
                    r_cfg.edge_limit <= i_cfg_data[etab_pkg::CNT_W-1:0];
                etab_pkg::CFG_MIN_EDGES:
                    r_cfg.min_edges <= i_cfg_data[etab_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    etab_fe u_fe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_push     (fe_push),
        .o_cmd      (fe_cmd)
    );

    etab_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_cmd   (fe_cmd),
        .o_full  (q_full),
        .i_pop   (be_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    etab_be u_be (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (q_cmd),
        .i_empty     (q_empty),
        .o_pop       (be_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_stat      (stat)
    );

    // Terms for the checks below
    assign shortest_ok = (stat.shortest != '0) &&
                         (stat.shortest <= etab_pkg::INITIAL_SHORTEST);
    assign too_few_out = o_out_valid && o_out_data.status;
    assign rates_zero  = (o_out_data.baud_rate == '0) && (o_out_data.measured_rate == '0);

    // Shortest interval stays non-zero, so the divisor is always valid
    `ETAB_CHECK(a_shortest_range, shortest_ok, "shortest interval out of range")

    // A too-few result carries zero rates
    `ETAB_IMPLY(a_too_few_zero, too_few_out, rates_zero, "too-few result with non-zero rate")

    // A new result only comes from the hold state
    `ETAB_IMPLY(a_out_from_hold, $rose(o_out_valid), $past(stat.res_pending), "bad result load")

endmodule
